/* design/assert_macros.svh */
// Assertion macros for the design files; only integer_partition_generator uses them.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`endif

`endif

/* design/ipg_pkg.sv */
// Package for the integer partition generator: item types and constants.
// No dependencies.
package ipg_pkg;

  localparam int unsigned PART_W        = 6;
  localparam int unsigned TOT_W         = 6;
  localparam int unsigned WIDE_W        = 7;
  localparam int unsigned MAX_TOTAL_DEF = 32;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [TOT_W-1:0]  total;
  } ipg_in_t;

  typedef struct packed {
    logic [PART_W-1:0] part;
    logic              last_part;
    logic              done_res;
  } ipg_out_t;

  localparam ipg_out_t DONE_ITEM = '{part: '0, last_part: 1'b0, done_res: 1'b1};

endpackage

/* design/ipg_part_mem.sv */
// Partition store: one write port, one read port with registered read data.
// Depends on ipg_pkg.
module ipg_part_mem #(
  parameter int unsigned DEPTH = ipg_pkg::MAX_TOTAL_DEF,
  parameter int unsigned IDX_W = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [ipg_pkg::PART_W-1:0] wr_data,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [ipg_pkg::PART_W-1:0] rd_data
);
  import ipg_pkg::*;

  logic [PART_W-1:0] mem [DEPTH];
  logic [PART_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/integer_partition_generator.sv */
// Integer partition generator top level: sequencer, state and output register.
// Depends on ipg_pkg, ipg_part_mem and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): action START loads a total
//   (clamped to MAX_TOTAL) and gives the single-part partition; action NEXT
//   gives the next partition in reverse lexicographic order. A NEXT with
//   nothing loaded, or after the all-ones partition, gives one done item.
//   Output channel (out_valid / out_stall / out_data): one item per part, the
//   final one flagged with last_part; a done item carries done_res only.
//   One item is worked on at a time; in_stall is high from acceptance until
//   the last result of that item has been taken.
//   A START with a zero total also gives one done item. The single memory
//   read port is used for one read per scan step and per emitted part.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset clears the sequencer, the loaded flag and the part count; the
//   partition store itself is not cleared.
`include "assert_macros.svh"

module integer_partition_generator #(
  parameter int unsigned MAX_TOTAL = ipg_pkg::MAX_TOTAL_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ipg_pkg::ipg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ipg_pkg::ipg_out_t out_data
);
  import ipg_pkg::*;

  localparam int unsigned IDX_W = (MAX_TOTAL > 1) ? $clog2(MAX_TOTAL) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TOTAL + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_TOTAL);
  localparam logic [WIDE_W-1:0] CLAMP_LIM = WIDE_W'(MAX_TOTAL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_REFILL,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT,
    S_DRAIN
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  rem_r;
  logic [PART_W-1:0] low_r;
  logic              active_r;
  logic              out_valid_r;
  ipg_out_t          out_data_r;

  logic              in_acc;
  logic [TOT_W-1:0]  tot_clamped;
  logic [WIDE_W-1:0] rem_w;
  logic [WIDE_W-1:0] low_w;
  logic [WIDE_W-1:0] fill_w;
  logic [CNT_W-1:0]  rem_nxt;
  logic              fill_go;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [PART_W-1:0] wr_data;
  logic [PART_W-1:0] rd_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tot_clamped = ({1'b0, in_data.total} > CLAMP_LIM) ? TOT_W'(MAX_TOTAL)
                                                          : in_data.total;

  // greedy refill: next part is min(remaining, lowered part)
  assign rem_w   = WIDE_W'(rem_r);
  assign low_w   = WIDE_W'(low_r);
  assign fill_w  = (rem_w < low_w) ? rem_w : low_w;
  assign rem_nxt = rem_r - CNT_W'(fill_w);
  assign fill_go = (rem_r != '0) && (ptr_r < CNT_MAX);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[IDX_W-1:0];
    wr_data = fill_w[PART_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        wr_en   = in_acc && (in_data.action == ACT_START) && (tot_clamped != '0);
        wr_addr = '0;
        wr_data = tot_clamped;
      end
      S_SCAN_CHK: begin
        wr_en   = (rd_data > PART_W'(1));
        wr_data = rd_data - PART_W'(1);
      end
      S_REFILL: begin
        wr_en   = fill_go;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  ipg_part_mem #(
    .DEPTH (MAX_TOTAL),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.action == ACT_START) begin
              if (tot_clamped == '0) begin
                active_r    <= 1'b0;
                cnt_r       <= '0;
                out_data_r  <= DONE_ITEM;
                out_valid_r <= 1'b1;
                state_r     <= S_DRAIN;
              end else begin
                active_r <= 1'b1;
                cnt_r    <= CNT_W'(1);
                ptr_r    <= '0;
                state_r  <= S_EMIT_RD;
              end
            end else if (!active_r || (cnt_r == '0)) begin
              out_data_r  <= DONE_ITEM;
              out_valid_r <= 1'b1;
              state_r     <= S_DRAIN;
            end else begin
              ptr_r   <= cnt_r - CNT_W'(1);
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (rd_data > PART_W'(1)) begin
            low_r   <= rd_data - PART_W'(1);
            rem_r   <= cnt_r - ptr_r;   // trailing ones plus the removed unit
            ptr_r   <= ptr_r + CNT_W'(1);
            state_r <= S_REFILL;
          end else if (ptr_r == '0) begin
            active_r    <= 1'b0;
            out_data_r  <= DONE_ITEM;
            out_valid_r <= 1'b1;
            state_r     <= S_DRAIN;
          end else begin
            ptr_r   <= ptr_r - CNT_W'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_REFILL: begin
          if (fill_go) begin
            rem_r <= rem_nxt;
            ptr_r <= ptr_r + CNT_W'(1);
          end else begin
            cnt_r   <= ptr_r;
            ptr_r   <= '0;
            state_r <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_data_r.part      <= rd_data;
          out_data_r.last_part <= ((ptr_r + CNT_W'(1)) == cnt_r);
          out_data_r.done_res  <= 1'b0;
          out_valid_r          <= 1'b1;
          state_r              <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_data_r.last_part) begin
              state_r <= S_IDLE;
            end else begin
              ptr_r   <= ptr_r + CNT_W'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        S_DRAIN: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_out_blocks_in, clk, rst_n, out_valid_r, in_stall)
  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_MAX)
  `ASSERT_IMPLY(a_refill_loaded, clk, rst_n, state_r == S_REFILL, active_r && (low_r != '0))
  `ASSERT_IMPLY(a_done_clean, clk, rst_n, out_valid_r && out_data_r.done_res, (out_data_r.part == '0) && !out_data_r.last_part)

endmodule

/* bench/testbench.sv */
// Testbench for integer_partition_generator: directed and random start/next items,
// partitions predicted in-bench and checked item by item. Depends on ipg_pkg.
`timescale 1ns / 1ps

module testbench;
  import ipg_pkg::*;

  localparam int unsigned MAX_T    = MAX_TOTAL_DEF;
  localparam int unsigned RAND_N   = 420;
  localparam int unsigned DRAIN_AT = 300;
  localparam int unsigned QUIET_LO = 120;
  localparam int unsigned QUIET_HI = 200;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ipg_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ipg_out_t out_data;

  ipg_in_t  request_q[$];
  ipg_out_t expected_parts_q[$];

  logic [PART_W-1:0] cur_parts[MAX_T];
  int unsigned       cur_count = 0;
  bit                loaded = 1'b0;

  int unsigned sent_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned hold_cycles = 0;
  bit          hold_done = 1'b0;
  bit          drained = 1'b0;

  integer_partition_generator #(.MAX_TOTAL(MAX_T)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  task automatic queue_expected(input ipg_out_t res);
    expected_parts_q.insert(expected_parts_q.size(), res);
  endtask

  // Steps the partition held in cur_parts and queues the parts, or the done item, it emits.
  task automatic advance_partition(input ipg_in_t it);
    int unsigned tot, r, rem, idx, lowered, x;
    bit found;
    ipg_out_t res;
    if (it.action == ACT_START) begin
      tot = 32'(it.total);
      if (tot > MAX_T) tot = MAX_T;
      if (tot == 0) begin
        loaded = 1'b0;
        cur_count = 0;
        queue_expected(DONE_ITEM);
        return;
      end
      cur_parts[0] = tot[PART_W-1:0];
      cur_count = 1;
      loaded = 1'b1;
    end else begin
      if (!loaded || cur_count == 0 || cur_count > MAX_T) begin
        queue_expected(DONE_ITEM);
        return;
      end
      found = 1'b0;
      r = cur_count;
      while (r > 0) begin
        r--;
        if (cur_parts[r] > 1) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        loaded = 1'b0;
        queue_expected(DONE_ITEM);
        return;
      end
      lowered = cur_parts[r] - 1;
      rem = cur_count - r;
      cur_parts[r] = lowered[PART_W-1:0];
      idx = r + 1;
      while (rem > 0 && idx < MAX_T) begin
        x = (rem < lowered) ? rem : lowered;
        cur_parts[idx] = x[PART_W-1:0];
        rem -= x;
        idx++;
      end
      cur_count = idx;
    end
    for (int unsigned k = 0; k < cur_count; k++) begin
      res.part      = cur_parts[k];
      res.last_part = (k + 1 == cur_count);
      res.done_res  = 1'b0;
      queue_expected(res);
    end
  endtask

  task automatic add_req(input logic act, input int unsigned tot);
    ipg_in_t it;
    it.action = act;
    it.total  = tot[TOT_W-1:0];
    request_q.insert(request_q.size(), it);
  endtask

  always @(posedge clk) begin : drive_proc
    logic    nxt_valid;
    ipg_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_partition(in_data);
        request_q.delete(0);
        sent_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && request_q.size() > 0) begin
        if (sent_cnt == DRAIN_AT && !drained) begin
          if (expected_parts_q.size() == 0) drained = 1'b1;
        end else if ((sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI) ||
                     $urandom_range(99) >= 9) begin
          nxt_valid = 1'b1;
          nxt_data  = request_q[0];
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  always @(posedge clk) begin : check_proc
    ipg_out_t want;
    logic     nxt_stall;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (expected_parts_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: part %0d last %0b done %0b",
                     out_data.part, out_data.last_part, out_data.done_res);
        end else begin
          want = expected_parts_q.pop_front();
          if (out_data.part !== want.part || out_data.last_part !== want.last_part ||
              out_data.done_res !== want.done_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("item %0d: expected part %0d last %0b done %0b, got %0d %0b %0b",
                       result_cnt, want.part, want.last_part, want.done_res,
                       out_data.part, out_data.last_part, out_data.done_res);
          end
        end
      end
      // one long hold-off so the block backs up onto its input
      if (hold_cycles > 0) begin
        hold_cycles--;
        nxt_stall = 1'b1;
      end else if (!hold_done && result_cnt >= 200) begin
        hold_done   = 1'b1;
        hold_cycles = 250;
        nxt_stall   = 1'b1;
      end else if (!(result_cnt >= 600 && result_cnt < 900)) begin
        nxt_stall = ($urandom_range(99) < 9);
      end
    end
    out_stall <= nxt_stall;
  end

  initial begin
    int unsigned n, tot, nexts, sel;
    // directed
    add_req(ACT_NEXT, 0);
    add_req(ACT_START, 0);
    add_req(ACT_NEXT, 5);
    add_req(ACT_START, 1);
    add_req(ACT_NEXT, 0);
    add_req(ACT_NEXT, 63);
    add_req(ACT_START, 4);
    repeat (5) add_req(ACT_NEXT, 0);
    add_req(ACT_START, 63);
    add_req(ACT_NEXT, 0);
    add_req(ACT_NEXT, 42);
    add_req(ACT_START, 33);
    add_req(ACT_START, 32);
    add_req(ACT_NEXT, 0);
    add_req(ACT_START, 2);
    add_req(ACT_NEXT, 21);
    add_req(ACT_NEXT, 0);
    // random: mostly start-then-next runs, some noise
    n = 0;
    while (n < RAND_N) begin
      if ($urandom_range(99) < 85) begin
        sel = $urandom_range(99);
        if (sel < 60)      tot = $urandom_range(7, 1);
        else if (sel < 85) tot = $urandom_range(14, 8);
        else if (sel < 95) tot = $urandom_range(32, 15);
        else               tot = $urandom_range(63, 33);
        nexts = (tot <= 7) ? $urandom_range(18) : $urandom_range(10);
        add_req(ACT_START, tot);
        n++;
        repeat (nexts) begin
          add_req(ACT_NEXT, $urandom_range(63));
          n++;
        end
      end else begin
        add_req(1'($urandom_range(1)), $urandom_range(63));
        n++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() > 0 || expected_parts_q.size() > 0 || in_valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* integer_partition_generator.f */
+incdir+design
design/ipg_pkg.sv
design/ipg_part_mem.sv
design/integer_partition_generator.sv
bench/testbench.sv
